>>> hdl/byte_stream_crc32_fnv1a64_macros.svh
// Assertion macros for the byte stream checksum block.
`ifndef BYTE_STREAM_CRC32_FNV1A64_MACROS_SVH
`define BYTE_STREAM_CRC32_FNV1A64_MACROS_SVH

`ifndef SYNTHESIS

`define BSCF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bscf assertion failed");

`define BSCF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bscf assertion failed");

`else

`define BSCF_ASSERT(label, clk, rst_n, prop)

`define BSCF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> hdl/bscf_pkg.sv
`default_nettype none

package bscf_pkg;

    localparam int COUNT_BITS = 48;
    localparam int TOTAL_BITS = 48;
    localparam int FNV_BITS   = 64;
    localparam int CRC_BITS   = 32;
    localparam int OUT_BITS   = TOTAL_BITS + FNV_BITS + CRC_BITS;

    localparam logic [FNV_BITS-1:0]   FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [FNV_BITS-1:0]   FNV_PRIME = 64'h0000_0100_0000_01B3;
    localparam logic [CRC_BITS-1:0]   CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_BITS-1:0]   CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    // Reflected CRC-32 update by one byte, one bit per step.
    function automatic logic [CRC_BITS-1:0] crc_fold_byte(
        input logic [CRC_BITS-1:0] crc,
        input logic [7:0]          b
    );
        logic [CRC_BITS-1:0] v;
        v = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
        end
        return v;
    endfunction

    // FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a sum of shifts.
    function automatic logic [FNV_BITS-1:0] fnv_fold_byte(
        input logic [FNV_BITS-1:0] h,
        input logic [7:0]          b
    );
        logic [FNV_BITS-1:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    function automatic logic [TOTAL_BITS-1:0] count_to_total(
        input logic [COUNT_BITS-1:0] c
    );
        logic [63:0] w;
        w = 64'(c);
        if (w > 64'(TOTAL_MAX))
        begin
            w = 64'(TOTAL_MAX);
        end
        return w[TOTAL_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/byte_stream_crc32_fnv1a64.sv
// Channel   Direction  tdata                       tuser          tlast
// s_axis    in         data_byte                   byte_present   end_of_blob
// m_axis    out        total_bytes, fnv, crc       -              -
//
// One input transaction is taken every cycle unless a stalled output holds it back;
// the work for a byte is done combinationally between the input register and the
// running state registers, and a blob's result then goes to the m_axis output register.
// The reset is asynchronous and active low; it clears the valid flags and the state.
// A stalled output only holds back input when the item waiting in the input register
// ends a blob; bytes inside a blob keep flowing.
`default_nettype none

`include "byte_stream_crc32_fnv1a64_macros.svh"

module byte_stream_crc32_fnv1a64
    import bscf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,  // [7:0] data_byte
    input  wire logic [0:0]          s_axis_tuser,  // [0] byte_present
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_BITS-1:0]      m_axis_tdata   // [47:0] total_bytes,
                                                    // [111:48] fnv_digest,
                                                    // [143:112] crc_digest
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_present_reg;
    logic                  in_last_reg;

    logic [CRC_BITS-1:0]   crc_reg;
    logic [FNV_BITS-1:0]   fnv_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                  in_go;
    logic [CRC_BITS-1:0]   crc_next;
    logic [FNV_BITS-1:0]   fnv_next;
    logic [COUNT_BITS-1:0] count_next;
    logic [FNV_BITS-1:0]   fnv_digest;

    assign in_go = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_go;

    always_comb
    begin
        crc_next   = crc_reg;
        fnv_next   = fnv_reg;
        count_next = count_reg;
        if (in_present_reg)
        begin
            crc_next = crc_fold_byte(crc_reg, in_byte_reg);
            fnv_next = fnv_fold_byte(fnv_reg, in_byte_reg);
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        fnv_digest = (fnv_next == '0) ? FNV_PRIME : fnv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
            fnv_reg       <= FNV_BASIS;
            count_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (in_go)
            begin
                if (in_last_reg)
                begin
                    crc_reg   <= CRC_INIT;
                    fnv_reg   <= FNV_BASIS;
                    count_reg <= '0;
                end
                else
                begin
                    crc_reg   <= crc_next;
                    fnv_reg   <= fnv_next;
                    count_reg <= count_next;
                end
            end

            if (in_go && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser[0];
            in_last_reg    <= s_axis_tlast;
        end
        if (in_go && in_last_reg)
        begin
            out_data_reg <= {crc_next ^ CRC_INIT, fnv_digest, count_to_total(count_next)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `BSCF_ASSERT(a_state_restart, clk, rst_n,
        (in_go && in_last_reg) |=>
            (crc_reg == CRC_INIT && fnv_reg == FNV_BASIS && count_reg == '0))
    `BSCF_ASSERT(a_idle_item_keeps_state, clk, rst_n,
        (in_go && !in_present_reg && !in_last_reg) |=>
            ($stable(crc_reg) && $stable(fnv_reg) && $stable(count_reg)))
    `BSCF_ASSERT(a_byte_counted, clk, rst_n,
        (in_go && in_present_reg && !in_last_reg) |=> (count_reg != '0))
    `BSCF_ASSERT(a_digest_nonzero, clk, rst_n,
        out_valid_reg |-> (out_data_reg[TOTAL_BITS+FNV_BITS-1:TOTAL_BITS] != '0))
    `BSCF_ASSERT_ALWAYS(a_reset_clears_valid, clk,
        !rst_n |=> (!out_valid_reg && !in_valid_reg))

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bscf_pkg::*;

    localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME = 64'd1099511628211;
    localparam logic [31:0] CRC_REFLECTED_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total;
        logic [63:0]           fnv;
        logic [31:0]           crc;
    } blob_digest_t;

    typedef struct {
        logic [7:0]   data;
        logic         present;
        logic         eob;
        logic         typed;
        blob_digest_t want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic [0:0]          s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;

    logic [31:0]           crc_acc;
    logic [63:0]           fnv_acc;
    logic [COUNT_BITS-1:0] byte_count;

    blob_digest_t digest_q[$];
    stim_row_t    directed_rows[$];
    int           error_count;
    bit           quiet;
    int           stall_left;

    byte_stream_crc32_fnv1a64 u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_digests();
        crc_acc    = 32'hFFFF_FFFF;
        fnv_acc    = HASH_BASIS;
        byte_count = '0;
    endfunction

    // Folds one item into the running sums; returns 1 when the item closes a blob.
    function automatic bit fold_item(input logic [7:0] b, input logic present,
                                     input logic eob, output blob_digest_t d);
        logic [31:0] c;
        d = '0;
        if (present)
        begin
            if (byte_count != {COUNT_BITS{1'b1}})
            begin
                byte_count = byte_count + COUNT_BITS'(1);
            end
            fnv_acc = (fnv_acc ^ {56'd0, b}) * HASH_PRIME;
            c = crc_acc ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_REFLECTED_POLY) : (c >> 1);
            end
            crc_acc = c;
        end
        if (!eob)
        begin
            return 1'b0;
        end
        d.total = (64'(byte_count) > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(byte_count);
        d.fnv   = (fnv_acc == 64'd0) ? HASH_PRIME : fnv_acc;
        d.crc   = ~crc_acc;
        clear_digests();
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic present,
                                    input logic eob, input logic typed,
                                    input blob_digest_t want);
        stim_row_t r;
        r.data    = b;
        r.present = present;
        r.eob     = eob;
        r.typed   = typed;
        r.want    = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input logic present, input logic eob,
                             input logic typed, input blob_digest_t want);
        int           gap;
        blob_digest_t d;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
        end
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = present;
        s_axis_tlast  = eob;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (fold_item(b, present, eob, d))
        begin
            digest_q.push_back(typed ? want : d);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (digest_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Output side: random back-pressure in bursts, none once the run is quiet.
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                m_axis_tready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 15);
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        blob_digest_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                note_mismatch("unexpected transaction", 64'd0, 64'(m_axis_tdata[47:0]));
            end
            else
            begin
                want = digest_q.pop_front();
                if (m_axis_tdata[47:0] !== want.total)
                begin
                    note_mismatch("total_bytes", 64'(want.total), 64'(m_axis_tdata[47:0]));
                end
                if (m_axis_tdata[111:48] !== want.fnv)
                begin
                    note_mismatch("fnv_digest", want.fnv, m_axis_tdata[111:48]);
                end
                if (m_axis_tdata[143:112] !== want.crc)
                begin
                    note_mismatch("crc_digest", 64'(want.crc), 64'(m_axis_tdata[143:112]));
                end
            end
        end
    end

    initial
    begin
        blob_digest_t empty_blob;
        string        digits;
        int           items_sent;
        int           blob_len;
        bit           paused;
        bit           split_end;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        error_count   = 0;
        quiet         = 1'b0;
        paused        = 1'b0;
        items_sent    = 0;
        digits        = "123456789";
        clear_digests();

        empty_blob.total = '0;
        empty_blob.fnv   = HASH_BASIS;
        empty_blob.crc   = 32'd0;

        // Empty blobs straight after reset, and an ignored item between them.
        add_row(8'h00, 1'b0, 1'b1, 1'b1, empty_blob);
        add_row(8'hFF, 1'b0, 1'b1, 1'b1, empty_blob);
        add_row(8'h5A, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hA5, 1'b0, 1'b1, 1'b1, empty_blob);
        // Single bytes at both extremes, byte and end in the same transaction.
        add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
        for (int i = 0; i < 9; i++)
        begin
            add_row(digits[i], 1'b1, (i == 8), 1'b0, '0);
        end
        // A blob with an ignored item inside and a separate end without a byte.
        add_row(8'hA5, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h5A, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h3C, 1'b0, 1'b1, 1'b1, empty_blob);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].data, directed_rows[i].present,
                      directed_rows[i].eob, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_results();

        while (items_sent < 1500)
        begin
            if (!paused && items_sent >= 700)
            begin
                paused = 1'b1;
                drain_results();
            end
            quiet     = (items_sent >= 1300);
            blob_len  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 12);
            split_end = (blob_len == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < blob_len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
                end
                send_item(8'($urandom), 1'b1, !split_end && (i == blob_len - 1), 1'b0, '0);
                items_sent++;
            end
            if (split_end)
            begin
                send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
                items_sent++;
            end
        end
        drain_results();

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
